>>> src/block_and_inode_bitmap_allocator_defines.svh
// ----------------------------------------------------------------------------
// Block and inode bitmap allocator assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_AND_INODE_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_AND_INODE_BITMAP_ALLOCATOR_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define BIA_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define BIA_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/bia_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap allocator package
// Types, codes and constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package bia_pkg;

   localparam int DEF_NUM_BLOCKS = 1024;
   localparam int DEF_NUM_INODES = 128;

   localparam int WORD_BITS  = 32;
   localparam int WORD_SHIFT = 5;

   localparam logic [9:0] RESET_DATA_START  = 10'd64;
   localparam logic [7:0] RESET_INODE_LIMIT = 8'd128;

   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_FORMAT = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;
   localparam logic [1:0] ST_NOTALLOC = 2'd3;

   localparam logic REG_DATA_START  = 1'b0;
   localparam logic REG_INODE_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      CS_INIT,
      CS_IDLE,
      CS_DECODE,
      CS_SCAN,
      CS_FREE_CHECK,
      CS_FORMAT,
      CS_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic       load_req;
      logic       scan_init;
      logic       scan_run;
      logic       free_read;
      logic       free_commit;
      logic       clear_init;
      logic       clear_run;
      logic       reload;
      logic       set_result;
      logic [1:0] result_code;
      logic       respond;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       count_zero;
      logic       range_empty;
      logic       index_bad;
      logic       hit;
      logic       miss;
      logic       clear_done;
      logic       rsp_free;
   } dp_status_type;

   function automatic logic [WORD_SHIFT-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [WORD_SHIFT-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = WORD_SHIFT'(i);
         end
      end
      return r;
   endfunction

endpackage

>>> src/bia_controller.sv
// ----------------------------------------------------------------------------
// Bitmap allocator controller
// Sequences reset clearing, allocate scans, frees, formats and the response.
// ----------------------------------------------------------------------------
`include "block_and_inode_bitmap_allocator_defines.svh"

module bia_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bia_pkg::dp_status_type st,
   output bia_pkg::ctrl_cmd_type  cmd
);
   import bia_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         CS_INIT: begin
            cmd.clear_run = 1'b1;
            if (st.clear_done) begin
               state_in = CS_IDLE;
            end
         end
         CS_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = CS_DECODE;
            end
         end
         CS_DECODE: begin
            case (st.op)
               OP_ALLOC: begin
                  if (st.count_zero || st.range_empty) begin
                     cmd.set_result  = 1'b1;
                     cmd.result_code = ST_FULL;
                     state_in        = CS_DONE;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = CS_SCAN;
                  end
               end
               OP_FREE: begin
                  if (st.index_bad) begin
                     cmd.set_result  = 1'b1;
                     cmd.result_code = ST_RANGE;
                     state_in        = CS_DONE;
                  end else begin
                     cmd.free_read = 1'b1;
                     state_in      = CS_FREE_CHECK;
                  end
               end
               OP_FORMAT: begin
                  cmd.clear_init = 1'b1;
                  state_in       = CS_FORMAT;
               end
               default: begin
                  cmd.set_result  = 1'b1;
                  cmd.result_code = ST_OK;
                  state_in        = CS_DONE;
               end
            endcase
         end
         CS_SCAN: begin
            cmd.scan_run = 1'b1;
            if (st.hit) begin
               state_in = CS_DONE;
            end else if (st.miss) begin
               cmd.set_result  = 1'b1;
               cmd.result_code = ST_FULL;
               state_in        = CS_DONE;
            end
         end
         CS_FREE_CHECK: begin
            cmd.free_commit = 1'b1;
            state_in        = CS_DONE;
         end
         CS_FORMAT: begin
            cmd.clear_run = 1'b1;
            if (st.clear_done) begin
               cmd.reload      = 1'b1;
               cmd.set_result  = 1'b1;
               cmd.result_code = ST_OK;
               state_in        = CS_DONE;
            end
         end
         CS_DONE: begin
            if (st.rsp_free) begin
               cmd.respond = 1'b1;
               state_in    = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_INIT;
         end
      endcase
   end

   `BIA_ASSERT_IMPLY(a_busy_stalls, state_ff != CS_IDLE, req_stall, "request taken while busy")
   `BIA_ASSERT_IMPLY(a_hit_miss_excl, st.hit, !st.miss, "scan hit and miss together")

endmodule

>>> src/bia_datapath.sv
// ----------------------------------------------------------------------------
// Bitmap allocator datapath
// Bitmap word memory, word scanner, pool counters, registers and response.
// ----------------------------------------------------------------------------
`include "block_and_inode_bitmap_allocator_defines.svh"

module bia_datapath #(
   parameter int NUM_BLOCKS = bia_pkg::DEF_NUM_BLOCKS,
   parameter int NUM_INODES = bia_pkg::DEF_NUM_INODES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_op,
   input  logic                  req_pool,
   input  logic [9:0]            req_index,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [9:0]            rsp_granted,
   output logic [9:0]            rsp_free_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [9:0]            csr_data,
   input  bia_pkg::ctrl_cmd_type  cmd,
   output bia_pkg::dp_status_type st
);
   import bia_pkg::*;

   localparam int BLK_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int INO_WORDS = (NUM_INODES + WORD_BITS - 1) / WORD_BITS;
   localparam int TOT_WORDS = BLK_WORDS + INO_WORDS;
   localparam int AW        = $clog2(TOT_WORDS);
   localparam int SW        = AW + 1;
   localparam int BCW       = $clog2(NUM_BLOCKS);
   localparam int ICW       = $clog2(NUM_INODES + 1);
   localparam int MW        = (BCW > ICW) ? BCW : ICW;
   localparam int CW        = ((MW > 10) ? MW : 10) + 2;

   localparam logic [BCW-1:0] BLK_CNT_RESET =
      (NUM_BLOCKS > int'(RESET_DATA_START)) ? BCW'(NUM_BLOCKS - int'(RESET_DATA_START)) : '0;
   localparam logic [ICW-1:0] INO_CNT_RESET =
      (int'(RESET_INODE_LIMIT) > NUM_INODES) ? ICW'(NUM_INODES) : ICW'(RESET_INODE_LIMIT);

   logic [WORD_BITS-1:0] mem [TOT_WORDS];

   logic [9:0]           data_start_ff;
   logic [7:0]           inode_limit_ff;
   logic [1:0]           op_ff;
   logic                 pool_ff;
   logic [9:0]           index_ff;
   logic [BCW-1:0]       blk_cnt_ff, blk_cnt_in;
   logic [ICW-1:0]       ino_cnt_ff, ino_cnt_in;
   logic [SW-1:0]        scan_addr_ff, scan_addr_in;
   logic [SW-1:0]        scan_end_ff, scan_end_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [SW-1:0]        rd_word_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic [9:0]           res_granted_ff, res_granted_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff;
   logic [9:0]           rsp_granted_ff;
   logic [9:0]           rsp_count_ff;

   logic [CW-1:0]        eff_ds, eff_lim, lim_nz, idx_cw, base, hit_pos;
   logic                 blk_range_empty, scan_more, found, hit, miss, bit_set;
   logic [SW-1:0]        free_addr, scan_start, scan_end, local_w;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] usable, cand;
   logic [WORD_SHIFT-1:0] hit_bit;
   logic                 we;
   logic [AW-1:0]        wa;
   logic [WORD_BITS-1:0] wd;

   assign csr_ready = 1'b1;

   always_comb begin
      eff_ds = (data_start_ff == '0) ? CW'(1) : CW'(data_start_ff);
      lim_nz = (inode_limit_ff == '0) ? CW'(1) : CW'(inode_limit_ff);
      eff_lim = (lim_nz > CW'(NUM_INODES)) ? CW'(NUM_INODES) : lim_nz;
      blk_range_empty = eff_ds >= CW'(NUM_BLOCKS);
      idx_cw = CW'(index_ff);

      free_addr = pool_ff ? (SW'(BLK_WORDS) + SW'(idx_cw >> WORD_SHIFT))
                          : SW'(idx_cw >> WORD_SHIFT);
      scan_start = pool_ff ? SW'(BLK_WORDS) : SW'(eff_ds >> WORD_SHIFT);
      scan_end = pool_ff ? (SW'(BLK_WORDS) + SW'((eff_lim - CW'(1)) >> WORD_SHIFT))
                         : SW'(BLK_WORDS - 1);
      scan_more = scan_addr_ff <= scan_end_ff;

      local_w = pool_ff ? (rd_word_ff - SW'(BLK_WORDS)) : rd_word_ff;
      base = CW'(local_w) << WORD_SHIFT;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (pool_ff) begin
            usable[b] = (base | CW'(b)) < eff_lim;
         end else begin
            usable[b] = ((base | CW'(b)) >= eff_ds) && ((base | CW'(b)) < CW'(NUM_BLOCKS));
         end
      end
      cand    = ~rd_data_ff & usable;
      found   = |cand;
      hit_bit = lowest_set(cand);
      hit_pos = base | CW'(hit_bit);
      hit     = cmd.scan_run && rd_vld_ff && found;
      miss    = cmd.scan_run && !rd_vld_ff && !scan_more;
      bit_set = rd_data_ff[index_ff[WORD_SHIFT-1:0]];

      rd_en   = cmd.free_read || (cmd.scan_run && scan_more);
      rd_addr = cmd.free_read ? free_addr[AW-1:0] : scan_addr_ff[AW-1:0];
   end

   always_comb begin
      we = 1'b0;
      wa = rd_word_ff[AW-1:0];
      wd = rd_data_ff;
      if (cmd.clear_run) begin
         we = 1'b1;
         wa = clr_addr_ff;
         wd = '0;
      end else if (hit) begin
         we = 1'b1;
         wd = rd_data_ff | (WORD_BITS'(1) << hit_bit);
      end else if (cmd.free_commit && bit_set) begin
         we = 1'b1;
         wd = rd_data_ff & ~(WORD_BITS'(1) << index_ff[WORD_SHIFT-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_word_ff <= SW'(rd_addr);
      end
   end

   always_comb begin
      scan_addr_in = scan_addr_ff;
      scan_end_in  = scan_end_ff;
      rd_vld_in    = 1'b0;
      if (cmd.scan_init) begin
         scan_addr_in = scan_start;
         scan_end_in  = scan_end;
      end else if (cmd.scan_run && scan_more) begin
         scan_addr_in = scan_addr_ff + SW'(1);
         rd_vld_in    = 1'b1;
      end

      clr_addr_in = clr_addr_ff;
      if (cmd.clear_init) begin
         clr_addr_in = '0;
      end else if (cmd.clear_run) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end

      blk_cnt_in = blk_cnt_ff;
      ino_cnt_in = ino_cnt_ff;
      if (cmd.reload) begin
         blk_cnt_in = blk_range_empty ? '0 : BCW'(CW'(NUM_BLOCKS) - eff_ds);
         ino_cnt_in = ICW'(eff_lim);
      end else if (hit) begin
         if (pool_ff) begin
            ino_cnt_in = ino_cnt_ff - ICW'(1);
         end else begin
            blk_cnt_in = blk_cnt_ff - BCW'(1);
         end
      end else if (cmd.free_commit && bit_set) begin
         if (pool_ff) begin
            ino_cnt_in = ino_cnt_ff + ICW'(1);
         end else begin
            blk_cnt_in = blk_cnt_ff + BCW'(1);
         end
      end

      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      if (cmd.set_result) begin
         res_status_in  = cmd.result_code;
         res_granted_in = '0;
      end else if (hit) begin
         res_status_in  = ST_OK;
         res_granted_in = 10'(hit_pos);
      end else if (cmd.free_commit) begin
         res_status_in  = bit_set ? ST_OK : ST_NOTALLOC;
         res_granted_in = '0;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_start_ff  <= RESET_DATA_START;
         inode_limit_ff <= RESET_INODE_LIMIT;
         blk_cnt_ff     <= BLK_CNT_RESET;
         ino_cnt_ff     <= INO_CNT_RESET;
         scan_addr_ff   <= '0;
         scan_end_ff    <= '0;
         rd_vld_ff      <= 1'b0;
         clr_addr_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DATA_START:  data_start_ff  <= csr_data;
               REG_INODE_LIMIT: inode_limit_ff <= csr_data[7:0];
               default:         data_start_ff  <= data_start_ff;
            endcase
         end
         blk_cnt_ff   <= blk_cnt_in;
         ino_cnt_ff   <= ino_cnt_in;
         scan_addr_ff <= scan_addr_in;
         scan_end_ff  <= scan_end_in;
         rd_vld_ff    <= rd_vld_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_op;
         pool_ff  <= req_pool;
         index_ff <= req_index;
      end
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      if (cmd.respond) begin
         rsp_status_ff  <= res_status_ff;
         rsp_granted_ff <= res_granted_ff;
         rsp_count_ff   <= pool_ff ? 10'(ino_cnt_ff) : 10'(blk_cnt_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_granted    = rsp_granted_ff;
   assign rsp_free_count = rsp_count_ff;

   always_comb begin
      st             = '0;
      st.op          = op_ff;
      st.count_zero  = pool_ff ? (ino_cnt_ff == '0) : (blk_cnt_ff == '0);
      st.range_empty = !pool_ff && blk_range_empty;
      st.index_bad   = pool_ff ? (idx_cw >= eff_lim)
                               : ((idx_cw < eff_ds) || (idx_cw >= CW'(NUM_BLOCKS)));
      st.hit         = hit;
      st.miss        = miss;
      st.clear_done  = clr_addr_ff == AW'(TOT_WORDS - 1);
      st.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

   `BIA_ASSERT_ALWAYS(a_blk_cnt_bound, blk_cnt_ff <= BCW'(NUM_BLOCKS - 1), "block count too large")
   `BIA_ASSERT_ALWAYS(a_ino_cnt_bound, ino_cnt_ff <= ICW'(NUM_INODES), "inode count too large")
   `BIA_ASSERT_IMPLY(a_granted_zero, rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_granted_ff == '0, "granted set on failure")

endmodule

>>> src/block_and_inode_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Block and inode bitmap allocator
// Two first-fit bitmap pools for data blocks and inodes.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_stall with op, pool and index; each request
// gives one response on rsp_valid/rsp_stall with status, granted index and the
// free count of the addressed pool. Registers data_start and inode_limit are
// written through csr_valid/csr_ready, which is always ready.
// Both bitmaps live in one memory of 32-bit words. An allocate reads one word
// per cycle and takes the lowest clear bit, scanning until a hit or the end
// of the pool. A free reads the addressed word and then clears the bit if set;
// a format clears every memory word and reloads both free counts; an unused op
// responds with status OK.
// After reset the block sweeps the whole memory to zero, one word a cycle,
// and holds req_stall high meanwhile.
// A finished response sits in an output register; the next request is taken
// while it waits, and a second response waits until the first is taken.
// ----------------------------------------------------------------------------
module block_and_inode_bitmap_allocator #(
   parameter int NUM_BLOCKS = bia_pkg::DEF_NUM_BLOCKS,
   parameter int NUM_INODES = bia_pkg::DEF_NUM_INODES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic       req_pool,
   input  logic [9:0] req_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [9:0] rsp_granted,
   output logic [9:0] rsp_free_count,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [9:0] csr_data
);
   import bia_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type st;

   bia_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   bia_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .NUM_INODES (NUM_INODES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_op),
      .req_pool       (req_pool),
      .req_index      (req_index),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_granted    (rsp_granted),
      .rsp_free_count (rsp_free_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .st             (st)
   );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block and inode bitmap allocator testbench
// Sends allocate, free, format and unused requests to both pools under random
// valid gaps and result stalls, across several register settings. Each
// accepted request is run through a behavioral copy of the two bitmaps and
// their free counts, and every response is compared field by field with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;
   import bia_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic       POOL_BLOCK  = 1'b0;
   localparam logic       POOL_INODE  = 1'b1;
   localparam int         HOLD_CYCLES = 300;
   localparam int         CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [1:0] status;
      logic [9:0] granted;
      logic [9:0] free_count;
   } outcome_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_op = OP_ALLOC;
   logic       req_pool = POOL_BLOCK;
   logic [9:0] req_index = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [9:0] rsp_granted;
   logic [9:0] rsp_free_count;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = REG_DATA_START;
   logic [9:0] csr_data = '0;

   bit [DEF_NUM_BLOCKS-1:0] blk_used;
   bit [DEF_NUM_INODES-1:0] ino_used;
   int                      blk_free;
   int                      ino_free;
   bit [9:0]                cfg_data_start = RESET_DATA_START;
   bit [7:0]                cfg_inode_limit = RESET_INODE_LIMIT;

   outcome_t awaited_outcomes[$];
   outcome_t want;
   int       error_count = 0;
   int       result_count = 0;
   int       cycle_count = 0;
   int       send_gap_pct = 0;
   int       rsp_stall_pct = 0;
   logic     rsp_hold = 1'b0;
   event     hold_start;

   block_and_inode_bitmap_allocator u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_pool       (req_pool),
      .req_index      (req_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_granted    (rsp_granted),
      .rsp_free_count (rsp_free_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= rsp_hold || ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   always begin
      @(hold_start);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   function automatic int first_data_block();
      return (cfg_data_start == 0) ? 1 : int'(cfg_data_start);
   endfunction

   function automatic int inode_span();
      if (cfg_inode_limit == 0) return 1;
      if (cfg_inode_limit > DEF_NUM_INODES) return DEF_NUM_INODES;
      return int'(cfg_inode_limit);
   endfunction

   function automatic void format_pools();
      blk_used = '0;
      ino_used = '0;
      blk_free = (DEF_NUM_BLOCKS > first_data_block()) ? DEF_NUM_BLOCKS - first_data_block() : 0;
      ino_free = inode_span();
   endfunction

   function automatic outcome_t allocator_outcome(input logic [1:0] op, input logic pool,
                                                  input logic [9:0] idx);
      outcome_t o;
      bit       found;
      o.status = ST_OK;
      o.granted = '0;
      found = 1'b0;
      if (op == OP_ALLOC) begin
         o.status = ST_FULL;
         if (pool == POOL_BLOCK && blk_free != 0) begin
            for (int i = first_data_block(); i < DEF_NUM_BLOCKS && !found; i++) begin
               if (!blk_used[i]) begin
                  blk_used[i] = 1'b1;
                  blk_free--;
                  o.granted = 10'(i);
                  o.status = ST_OK;
                  found = 1'b1;
               end
            end
         end else if (pool == POOL_INODE && ino_free != 0) begin
            for (int i = 0; i < inode_span() && !found; i++) begin
               if (!ino_used[i]) begin
                  ino_used[i] = 1'b1;
                  ino_free--;
                  o.granted = 10'(i);
                  o.status = ST_OK;
                  found = 1'b1;
               end
            end
         end
      end else if (op == OP_FREE) begin
         if (pool == POOL_BLOCK) begin
            if (int'(idx) < first_data_block()) begin
               o.status = ST_RANGE;
            end else if (!blk_used[idx]) begin
               o.status = ST_NOTALLOC;
            end else begin
               blk_used[idx] = 1'b0;
               blk_free++;
            end
         end else begin
            if (int'(idx) >= inode_span()) begin
               o.status = ST_RANGE;
            end else if (!ino_used[idx]) begin
               o.status = ST_NOTALLOC;
            end else begin
               ino_used[idx] = 1'b0;
               ino_free++;
            end
         end
      end else if (op == OP_FORMAT) begin
         format_pools();
      end
      o.free_count = (pool == POOL_BLOCK) ? 10'(blk_free) : 10'(ino_free);
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < 40) begin
         $display("ERROR: result %0d: %s", result_count, msg);
      end
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_outcomes.size() == 0) begin
            report_mismatch("transaction arrived with nothing outstanding");
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            end
            if (rsp_granted !== want.granted) begin
               report_mismatch($sformatf("granted %0d, expected %0d", rsp_granted,
                                         want.granted));
            end
            if (rsp_free_count !== want.free_count) begin
               report_mismatch($sformatf("free_count %0d, expected %0d", rsp_free_count,
                                         want.free_count));
            end
         end
         result_count++;
      end
   end

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_gap_pct = send_pct;
      rsp_stall_pct <= stall_pct;
   endtask

   task automatic send_request(input logic [1:0] op, input logic pool, input logic [9:0] idx);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_pool <= pool;
      req_index <= idx;
      do @(posedge clock); while (req_stall !== 1'b0);
      awaited_outcomes.push_back(allocator_outcome(op, pool, idx));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic reg_sel, input logic [9:0] value);
      while (req_stall !== 1'b0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_sel;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (reg_sel == REG_DATA_START) begin
         cfg_data_start = value;
      end else begin
         cfg_inode_limit = value[7:0];
      end
      @(posedge clock);
   endtask

   task automatic send_random_request();
      int         pick;
      int         near;
      logic [1:0] op;
      logic       pool;
      logic [9:0] idx;
      pick = $urandom_range(0, 99);
      if (pick < 46) begin
         op = OP_ALLOC;
      end else if (pick < 94) begin
         op = OP_FREE;
      end else if (pick < 97) begin
         op = OP_FORMAT;
      end else begin
         op = OP_UNUSED;
      end
      pool = 1'($urandom_range(0, 1));
      idx = 10'($urandom_range(0, 1023));
      if (op == OP_FREE && $urandom_range(0, 3) != 0) begin
         if (pool == POOL_BLOCK) begin
            near = first_data_block() + $urandom_range(0, 47);
            idx = (near > DEF_NUM_BLOCKS - 1) ? 10'(DEF_NUM_BLOCKS - 1) : 10'(near);
         end else begin
            idx = 10'($urandom_range(0, inode_span() - 1));
         end
      end
      send_request(op, pool, idx);
   endtask

   task automatic test_reset_defaults();
      send_request(OP_ALLOC, POOL_BLOCK, 10'd1023);
      send_request(OP_ALLOC, POOL_INODE, 10'd0);
      send_request(OP_FREE, POOL_BLOCK, 10'd64);
      send_request(OP_FREE, POOL_BLOCK, 10'd64);
      send_request(OP_FREE, POOL_BLOCK, 10'd63);
      send_request(OP_FREE, POOL_BLOCK, 10'd1023);
      send_request(OP_FREE, POOL_INODE, 10'd0);
      send_request(OP_FREE, POOL_INODE, 10'd127);
      send_request(OP_FREE, POOL_INODE, 10'd128);
      send_request(OP_UNUSED, POOL_BLOCK, 10'd1023);
      send_request(OP_FORMAT, POOL_INODE, 10'd682);
      send_request(OP_UNUSED, POOL_INODE, 10'd341);
      wait_for_results();
   endtask

   task automatic test_register_corners();
      write_register(REG_DATA_START, 10'd0);
      write_register(REG_INODE_LIMIT, 10'h300);
      send_request(OP_FORMAT, POOL_BLOCK, 10'd0);
      send_request(OP_ALLOC, POOL_BLOCK, 10'd0);
      send_request(OP_FREE, POOL_BLOCK, 10'd0);
      send_request(OP_ALLOC, POOL_INODE, 10'd0);
      send_request(OP_ALLOC, POOL_INODE, 10'd0);
      send_request(OP_FREE, POOL_INODE, 10'd1);
      wait_for_results();
      write_register(REG_DATA_START, 10'd1023);
      write_register(REG_INODE_LIMIT, 10'h0FF);
      send_request(OP_ALLOC, POOL_BLOCK, 10'd0);
      send_request(OP_ALLOC, POOL_BLOCK, 10'd0);
      send_request(OP_FORMAT, POOL_BLOCK, 10'd0);
      send_request(OP_ALLOC, POOL_BLOCK, 10'd0);
      send_request(OP_ALLOC, POOL_BLOCK, 10'd0);
      send_request(OP_FREE, POOL_BLOCK, 10'd1023);
      send_request(OP_FREE, POOL_INODE, 10'd127);
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int count, input logic [9:0] data_start,
                                      input logic [9:0] inode_limit, input bit reformat);
      write_register(REG_DATA_START, data_start);
      write_register(REG_INODE_LIMIT, inode_limit);
      if (reformat) begin
         send_request(OP_FORMAT, 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
      end
      repeat (count) send_random_request();
      wait_for_results();
   endtask

   task automatic test_backpressure();
      -> hold_start;
      repeat (40) send_random_request();
      wait_for_results();
      repeat (20) send_random_request();
      wait_for_results();
   endtask

   initial begin
      format_pools();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      set_idling(31, 73);
      test_reset_defaults();
      test_register_corners();
      test_random_traffic(150, 10'd64, 10'd128, 1'b1);
      test_random_traffic(120, 10'd1, 10'd8, 1'b1);
      test_random_traffic(60, 10'd1023, 10'h3FF, 1'b0);

      set_idling(73, 31);
      test_random_traffic(150, 10'd512, 10'd40, 1'b1);
      test_random_traffic(100, 10'd0, 10'h200, 1'b1);
      test_random_traffic(100, 10'd900, 10'd129, 1'b1);

      set_idling(0, 0);
      test_random_traffic(150, 10'd1, 10'd128, 1'b0);
      test_backpressure();
      test_random_traffic(70, 10'd64, 10'd128, 1'b1);

      wait_for_results();
      repeat (64) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/bia_pkg.sv
src/bia_controller.sv
src/bia_datapath.sv
src/block_and_inode_bitmap_allocator.sv
tb/testbench.sv
